@@ rtl/stq_pkg.sv @@
package stq_pkg;

  // default sizes
  localparam int unsigned MAX_EVENTS_DEF = 16;
  localparam int unsigned TICK_BITS_DEF  = 48;
  localparam int unsigned TAG_BITS_DEF   = 16;

  // fixed field widths
  localparam int unsigned FREQ_BITS  = 32;
  localparam int unsigned MS_BITS    = 32;
  localparam int unsigned KIND_BITS  = 2;
  localparam int unsigned RTYPE_BITS = 2;
  localparam int unsigned PROD_BITS  = FREQ_BITS + MS_BITS;

  // millisecond scaling
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned REM_BITS   = $clog2(MS_PER_SEC);

  localparam logic [FREQ_BITS-1:0] FREQ_RESET = 32'd19200000;

  // item function codes
  localparam logic FUNC_ADD     = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  // event kinds
  localparam logic [KIND_BITS-1:0] KIND_LOG     = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_WAKE    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_PREEMPT = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED  = 2'd3;

  // result codes
  localparam logic [RTYPE_BITS-1:0] RES_ADD_OK   = 2'd0;
  localparam logic [RTYPE_BITS-1:0] RES_ADD_FULL = 2'd1;
  localparam logic [RTYPE_BITS-1:0] RES_FIRED    = 2'd2;
  localparam logic [RTYPE_BITS-1:0] RES_SVC_DONE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE_RD,
    ST_PRE_EV,
    ST_FIND,
    ST_CALC,
    ST_HEAD_EV,
    ST_HEAD_INT,
    ST_WALK_RD,
    ST_WALK_LK,
    ST_WALK_EV,
    ST_LINK_NEW,
    ST_LINK_PREV,
    ST_SVC_RD,
    ST_SVC_EV,
    ST_OUT
  } stq_state_t;

endpackage

@@ rtl/sorted_timer_event_queue.sv @@
// Sorted timer event queue: a pool of timer entries linked in deadline order.
// Input channel (in_valid/in_ready): one word is an add (in_func 0) or a
// service (in_func 1). An add turns in_delay_ms into a deadline using the
// cfg counter frequency and inserts it; a service pops every entry at or
// before in_now. Result channel (out_valid/out_ready): an add gives one word,
// a service gives one fired word per expired entry and then a done word;
// out_last marks the final word of an item.
// Config: cfg_wr_en/cfg_wr_data write the counter frequency; the user must
// write it in idle only; the block does not enforce this. One item at a time;
// in_ready is high only when idle. An add scans for a free slot one slot per
// cycle while the divide by 1000 overlaps the scan, then steps past the head
// through ST_WALK_RD, ST_WALK_LK, ST_WALK_EV per entry; a preempt add first
// visits each queued entry in ST_PRE_RD, ST_PRE_EV. A service takes ST_SVC_RD,
// ST_SVC_EV, ST_OUT per head entry (ST_SVC_RD, ST_OUT when the queue is empty).
// Reset (rst_n low, synchronous) empties the queue, clears the timer enable
// and restores the default frequency; no clearing pass is needed.
// A stalled receiver holds the result register; the block waits on it and
// the next word of a service is produced once the current one is taken.
module sorted_timer_event_queue
  import stq_pkg::*;
#(
  parameter int unsigned MAX_EVENTS = MAX_EVENTS_DEF,
  parameter int unsigned TICK_BITS  = TICK_BITS_DEF,
  parameter int unsigned TAG_BITS   = TAG_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [FREQ_BITS-1:0]  cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [TICK_BITS-1:0]  in_now,
  input  logic [MS_BITS-1:0]    in_delay_ms,
  input  logic [KIND_BITS-1:0]  in_event_kind,
  input  logic [TAG_BITS-1:0]   in_event_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RTYPE_BITS-1:0] out_result_type,
  output logic [KIND_BITS-1:0]  out_fired_kind,
  output logic [TAG_BITS-1:0]   out_fired_tag,
  output logic                  out_reload,
  output logic [TICK_BITS-1:0]  out_timer_interval,
  output logic                  out_timer_enable,
  output logic                  out_last
);

  localparam int unsigned AW   = $clog2(MAX_EVENTS);
  localparam int unsigned IDXW = $clog2(MAX_EVENTS + 1);
  localparam int unsigned DW   = TICK_BITS + KIND_BITS + TAG_BITS;
  localparam logic [IDXW-1:0] LIST_END = IDXW'(MAX_EVENTS);
  localparam logic [PROD_BITS:0] TMASK = ((PROD_BITS+1)'(1) << TICK_BITS) - 1'b1;

  typedef struct packed {
    logic [RTYPE_BITS-1:0] rtype;
    logic [KIND_BITS-1:0]  kind;
    logic [TAG_BITS-1:0]   tag;
    logic                  reload;
    logic [TICK_BITS-1:0]  interval;
    logic                  enable;
    logic                  last;
  } res_t;

  stq_state_t state_r, state_nxt;

  logic [FREQ_BITS-1:0]  freq_r;
  logic [TICK_BITS-1:0]  now_r, now_nxt;
  logic [MS_BITS-1:0]    ms_r, ms_nxt;
  logic [KIND_BITS-1:0]  kind_r, kind_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [TICK_BITS-1:0]  deadline_r, deadline_nxt;
  logic [AW-1:0]         cur_r, cur_nxt;
  logic [IDXW-1:0]       prev_r, prev_nxt;
  logic [IDXW-1:0]       nxt_r, nxt_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [IDXW-1:0]       idx_r, idx_nxt;
  logic [IDXW-1:0]       head_r, head_nxt;
  logic                  cnt_on_r, cnt_on_nxt;
  logic [MAX_EVENTS-1:0] used_r, used_nxt;
  res_t                  pend_r, pend_nxt;
  res_t                  out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  out_free;
  logic [KIND_BITS-1:0]  in_kind_fix;

  // divider unit
  logic                  dv_start;
  logic                  dv_busy;
  logic [PROD_BITS-1:0]  dv_quot;

  // memories
  logic                  data_we;
  logic [AW-1:0]         data_waddr, data_raddr;
  logic [DW-1:0]         data_wdata, data_rd;
  logic                  link_we;
  logic [AW-1:0]         link_waddr, link_raddr;
  logic [IDXW-1:0]       link_wdata, link_rd;

  logic [TICK_BITS-1:0]  rd_dl;
  logic [KIND_BITS-1:0]  rd_kind;
  logic [TAG_BITS-1:0]   rd_tag;

  // shared subtractor
  logic [TICK_BITS-1:0]  op_a, op_b;
  logic [TICK_BITS:0]    diff;
  logic                  borrow;
  logic [TICK_BITS-1:0]  diff_val;

  // deadline adder with saturation
  logic [PROD_BITS:0]    dl_sum;
  logic [TICK_BITS-1:0]  dl_calc;

  stq_dline u_dline (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .freq  (freq_r),
    .ms    (ms_nxt),
    .busy  (dv_busy),
    .quot  (dv_quot)
  );

  stq_ram #(.WIDTH(DW), .DEPTH(MAX_EVENTS)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rd)
  );

  stq_ram #(.WIDTH(IDXW), .DEPTH(MAX_EVENTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  assign rd_dl   = data_rd[TICK_BITS-1:0];
  assign rd_kind = data_rd[TICK_BITS +: KIND_BITS];
  assign rd_tag  = data_rd[TICK_BITS+KIND_BITS +: TAG_BITS];

  assign diff     = {1'b0, op_a} - {1'b0, op_b};
  assign borrow   = diff[TICK_BITS];
  assign diff_val = diff[TICK_BITS-1:0];

  assign dl_sum  = {1'b0, PROD_BITS'(now_r)} + {1'b0, dv_quot};
  assign dl_calc = (dl_sum > TMASK) ? TMASK[TICK_BITS-1:0] : dl_sum[TICK_BITS-1:0];

  assign out_free    = !out_valid_r || out_ready;
  assign in_kind_fix = (in_event_kind == KIND_UNUSED) ? KIND_LOG : in_event_kind;
  assign in_ready    = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    ms_nxt        = ms_r;
    kind_nxt      = kind_r;
    tag_nxt       = tag_r;
    deadline_nxt  = deadline_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    nxt_nxt       = nxt_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    cnt_on_nxt    = cnt_on_r;
    used_nxt      = used_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dv_start      = 1'b0;
    data_we       = 1'b0;
    data_waddr    = slot_r;
    data_wdata    = {tag_r, kind_r, dl_calc};
    data_raddr    = cur_r;
    link_we       = 1'b0;
    link_waddr    = slot_r;
    link_wdata    = nxt_r;
    link_raddr    = cur_r;
    op_a          = deadline_r;
    op_b          = now_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt  = in_now;
          ms_nxt   = in_delay_ms;
          kind_nxt = in_kind_fix;
          tag_nxt  = in_event_tag;
          idx_nxt  = '0;
          if (in_func == FUNC_SERVICE) begin
            state_nxt = ST_SVC_RD;
          end else begin
            dv_start = 1'b1;
            if (in_kind_fix == KIND_PREEMPT && head_r != LIST_END) begin
              cur_nxt   = head_r[AW-1:0];
              prev_nxt  = LIST_END;
              state_nxt = ST_PRE_RD;
            end else begin
              state_nxt = ST_FIND;
            end
          end
        end
      end

      // drop queued preempt entries
      ST_PRE_RD: begin
        state_nxt = ST_PRE_EV;
      end

      ST_PRE_EV: begin
        if (rd_kind == KIND_PREEMPT) begin
          used_nxt[cur_r] = 1'b0;
          if (prev_r == LIST_END) begin
            head_nxt = link_rd;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_r[AW-1:0];
            link_wdata = link_rd;
          end
        end else begin
          prev_nxt = IDXW'(cur_r);
        end
        if (link_rd == LIST_END) begin
          state_nxt = ST_FIND;
        end else begin
          cur_nxt   = link_rd[AW-1:0];
          state_nxt = ST_PRE_RD;
        end
      end

      // lowest free slot
      ST_FIND: begin
        if (idx_r == LIST_END) begin
          pend_nxt        = '0;
          pend_nxt.rtype  = RES_ADD_FULL;
          pend_nxt.enable = cnt_on_r;
          pend_nxt.last   = 1'b1;
          state_nxt       = ST_OUT;
        end else if (!used_r[idx_r[AW-1:0]]) begin
          slot_nxt  = idx_r[AW-1:0];
          state_nxt = ST_CALC;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // store the new entry once the deadline is known
      ST_CALC: begin
        data_raddr = head_r[AW-1:0];
        if (!dv_busy) begin
          data_we          = 1'b1;
          used_nxt[slot_r] = 1'b1;
          deadline_nxt     = dl_calc;
          state_nxt        = ST_HEAD_EV;
        end
      end

      ST_HEAD_EV: begin
        op_a = deadline_r;
        op_b = rd_dl;
        if (head_r == LIST_END || borrow) begin
          link_we    = 1'b1;
          link_wdata = head_r;
          head_nxt   = IDXW'(slot_r);
          cnt_on_nxt = 1'b1;
          state_nxt  = ST_HEAD_INT;
        end else begin
          cur_nxt   = head_r[AW-1:0];
          state_nxt = ST_WALK_RD;
        end
      end

      ST_HEAD_INT: begin
        op_a            = deadline_r;
        op_b            = now_r;
        pend_nxt        = '0;
        pend_nxt.rtype  = RES_ADD_OK;
        pend_nxt.reload = 1'b1;
        pend_nxt.interval = (diff_val == '0) ? TICK_BITS'(1) : diff_val;
        pend_nxt.enable = 1'b1;
        pend_nxt.last   = 1'b1;
        state_nxt       = ST_OUT;
      end

      // walk to the insertion point
      ST_WALK_RD: begin
        state_nxt = ST_WALK_LK;
      end

      ST_WALK_LK: begin
        nxt_nxt    = link_rd;
        data_raddr = link_rd[AW-1:0];
        if (link_rd == LIST_END) begin
          state_nxt = ST_LINK_NEW;
        end else begin
          state_nxt = ST_WALK_EV;
        end
      end

      ST_WALK_EV: begin
        op_a = rd_dl;
        op_b = deadline_r;
        if (borrow) begin
          cur_nxt   = nxt_r[AW-1:0];
          state_nxt = ST_WALK_RD;
        end else begin
          state_nxt = ST_LINK_NEW;
        end
      end

      ST_LINK_NEW: begin
        link_we    = 1'b1;
        link_waddr = slot_r;
        link_wdata = nxt_r;
        state_nxt  = ST_LINK_PREV;
      end

      ST_LINK_PREV: begin
        link_we         = 1'b1;
        link_waddr      = cur_r;
        link_wdata      = IDXW'(slot_r);
        pend_nxt        = '0;
        pend_nxt.rtype  = RES_ADD_OK;
        pend_nxt.enable = cnt_on_r;
        pend_nxt.last   = 1'b1;
        state_nxt       = ST_OUT;
      end

      // service: pop expired head entries
      ST_SVC_RD: begin
        data_raddr = head_r[AW-1:0];
        link_raddr = head_r[AW-1:0];
        if (head_r == LIST_END) begin
          cnt_on_nxt     = 1'b0;
          pend_nxt       = '0;
          pend_nxt.rtype = RES_SVC_DONE;
          pend_nxt.last  = 1'b1;
          state_nxt      = ST_OUT;
        end else begin
          state_nxt = ST_SVC_EV;
        end
      end

      ST_SVC_EV: begin
        op_a     = rd_dl;
        op_b     = now_r;
        pend_nxt = '0;
        if (!borrow && diff_val != '0) begin
          pend_nxt.rtype    = RES_SVC_DONE;
          pend_nxt.reload   = 1'b1;
          pend_nxt.interval = diff_val;
          pend_nxt.enable   = cnt_on_r;
          pend_nxt.last     = 1'b1;
        end else begin
          pend_nxt.rtype  = RES_FIRED;
          pend_nxt.kind   = rd_kind;
          pend_nxt.tag    = rd_tag;
          pend_nxt.enable = cnt_on_r;
          used_nxt[head_r[AW-1:0]] = 1'b0;
          head_nxt = link_rd;
        end
        state_nxt = ST_OUT;
      end

      // hand the word to the output register
      ST_OUT: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pend_r.last ? ST_IDLE : ST_SVC_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      freq_r      <= FREQ_RESET;
      head_r      <= LIST_END;
      cnt_on_r    <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_on_r    <= cnt_on_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        freq_r <= cfg_wr_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    ms_r       <= ms_nxt;
    kind_r     <= kind_nxt;
    tag_r      <= tag_nxt;
    deadline_r <= deadline_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    nxt_r      <= nxt_nxt;
    slot_r     <= slot_nxt;
    idx_r      <= idx_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_type    = out_r.rtype;
  assign out_fired_kind     = out_r.kind;
  assign out_fired_tag      = out_r.tag;
  assign out_reload         = out_r.reload;
  assign out_timer_interval = out_r.interval;
  assign out_timer_enable   = out_r.enable;
  assign out_last           = out_r.last;

endmodule

@@ rtl/stq_ram.sv @@
module stq_ram
  import stq_pkg::*;
#(
  parameter int unsigned WIDTH = TICK_BITS_DEF,
  parameter int unsigned DEPTH = MAX_EVENTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/stq_dline.sv @@
module stq_dline
  import stq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [FREQ_BITS-1:0] freq,
  input  logic [MS_BITS-1:0]   ms,
  output logic                 busy,
  output logic [PROD_BITS-1:0] quot
);

  // divide by 1000 one 16-bit digit per cycle, reciprocal multiply per digit
  localparam int unsigned DIG_BITS = 16;
  localparam int unsigned NDIG     = PROD_BITS / DIG_BITS;
  localparam int unsigned CNT_BITS = $clog2(NDIG);
  localparam int unsigned X_BITS   = REM_BITS + DIG_BITS;
  localparam int unsigned SHIFT    = X_BITS + REM_BITS;
  localparam int unsigned RCP_BITS = SHIFT - REM_BITS + 1;
  localparam int unsigned MUL_BITS = X_BITS + RCP_BITS;
  localparam logic [RCP_BITS-1:0] RECIP =
    RCP_BITS'(((64'd1 << SHIFT) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));
  localparam logic [X_BITS-1:0] DIVISOR = X_BITS'(MS_PER_SEC);

  logic                 busy_r, busy_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [PROD_BITS-1:0] work_r, work_nxt;
  logic [PROD_BITS-1:0] quot_r, quot_nxt;
  logic [REM_BITS-1:0]  rem_r, rem_nxt;
  logic [X_BITS-1:0]    x;
  logic [MUL_BITS-1:0]  mul;
  logic [DIG_BITS-1:0]  qdig;
  logic [X_BITS-1:0]    qmul;

  // remainder and next dividend digit give one quotient digit
  always_comb begin
    x        = {rem_r, work_r[PROD_BITS-1 -: DIG_BITS]};
    mul      = MUL_BITS'(x) * MUL_BITS'(RECIP);
    qdig     = mul[SHIFT +: DIG_BITS];
    qmul     = X_BITS'(qdig) * DIVISOR;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      work_nxt = PROD_BITS'(freq) * PROD_BITS'(ms);
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = REM_BITS'(x - qmul);
      work_nxt = {work_r[PROD_BITS-DIG_BITS-1:0], {DIG_BITS{1'b0}}};
      quot_nxt = {quot_r[PROD_BITS-DIG_BITS-1:0], qdig};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_BITS'(NDIG - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r  <= cnt_nxt;
    work_r <= work_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule
